>>> rtl/expression_token_lexer_defines.svh
// Assertion macros shared by the lexer RTL.
`ifndef EXPRESSION_TOKEN_LEXER_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define ELEX_ASSERT_NOW(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define ELEX_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/elex_pkg.sv
// Shared types, constants and helpers of the expression token lexer.
package elex_pkg;

  localparam int unsigned ELEX_POSITION_BITS = 16;
  localparam int unsigned ELEX_LENGTH_BITS   = 8;

  localparam int unsigned TOKEN_START_W  = 16;
  localparam int unsigned TOKEN_LENGTH_W = 8;
  localparam int unsigned TOKEN_LINE_W   = 16;
  localparam int unsigned PREFIX_W       = 24;

  // Result queue: two slots per item plus headroom for back-to-back transfers
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    TK_LPAREN = 4'd0,
    TK_RPAREN = 4'd1,
    TK_PLUS   = 4'd2,
    TK_MINUS  = 4'd3,
    TK_STAR   = 4'd4,
    TK_SLASH  = 4'd5,
    TK_SEMI   = 4'd6,
    TK_NUMBER = 4'd7,
    TK_IDENT  = 4'd8,
    TK_DIV    = 4'd9,
    TK_MOD    = 4'd10,
    TK_EOF    = 4'd11,
    TK_ERROR  = 4'd12
  } elex_kind_e;

  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_NUM  = 2'd1,
    RUN_WORD = 2'd2
  } elex_run_e;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  // Keywords packed first byte highest
  localparam logic [PREFIX_W-1:0] WORD_DIV = 24'h646976;
  localparam logic [PREFIX_W-1:0] WORD_MOD = 24'h6D6F64;

  localparam logic [TOKEN_LINE_W-1:0] LINE_MAX = '1;

  typedef struct packed {
    elex_kind_e                kind;
    logic [TOKEN_START_W-1:0]  start;
    logic [TOKEN_LENGTH_W-1:0] length;
    logic [TOKEN_LINE_W-1:0]   line;
    logic                      last;
  } elex_token_t;

  // Up to two tokens produced by one character
  typedef struct packed {
    logic [1:0]  count;
    elex_token_t tok0;
    elex_token_t tok1;
  } elex_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

>>> rtl/elex_channels.sv
// Handshake channel interfaces: character input and token output.
interface elex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_marker;

  modport source (output valid, output char_code, output end_marker, input ready);
  modport sink   (input valid, input char_code, input end_marker, output ready);
endinterface

interface elex_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [7:0]  token_length;
  logic [15:0] token_line;
  logic        last_of_run;

  modport source (
    output valid, output token_kind, output token_start, output token_length,
    output token_line, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input token_start, input token_length,
    input token_line, input last_of_run, output ready
  );
endinterface

>>> rtl/elex_classify.sv
// Per-character scan step: classifies one byte against the run state.
module elex_classify import elex_pkg::*; #(
  parameter int unsigned POSITION_BITS = ELEX_POSITION_BITS,
  parameter int unsigned LENGTH_BITS   = ELEX_LENGTH_BITS
) (
  input  logic [7:0]               char_code_i,
  input  logic                     end_marker_i,
  input  elex_run_e                run_kind_i,
  input  logic [POSITION_BITS-1:0] run_start_i,
  input  logic [LENGTH_BITS-1:0]   run_length_i,
  input  logic [PREFIX_W-1:0]      word_prefix_i,
  input  logic [POSITION_BITS-1:0] char_pos_i,
  input  logic [TOKEN_LINE_W-1:0]  line_i,
  output elex_run_e                run_kind_o,
  output logic [POSITION_BITS-1:0] run_start_o,
  output logic [LENGTH_BITS-1:0]   run_length_o,
  output logic [PREFIX_W-1:0]      word_prefix_o,
  output logic [POSITION_BITS-1:0] char_pos_o,
  output logic [TOKEN_LINE_W-1:0]  line_o,
  output elex_push_t               push_o
);

  localparam logic [LENGTH_BITS-1:0] LenMax   = '1;
  localparam logic [LENGTH_BITS-1:0] LenThree = LENGTH_BITS'(3);

  logic [POSITION_BITS+TOKEN_START_W-1:0]  run_start_ext;
  logic [POSITION_BITS+TOKEN_START_W-1:0]  char_pos_ext;
  logic [LENGTH_BITS+TOKEN_LENGTH_W-1:0]   run_len_ext;
  logic        is_dig;
  logic        is_alp;
  logic        extend;
  logic        flush_valid;
  elex_token_t flush_tok;
  logic        second_valid;
  elex_token_t second_tok;

  // Fit positions and lengths to the fixed token field widths
  assign run_start_ext = {{TOKEN_START_W{1'b0}}, run_start_i};
  assign char_pos_ext  = {{TOKEN_START_W{1'b0}}, char_pos_i};
  assign run_len_ext   = {{TOKEN_LENGTH_W{1'b0}}, run_length_i};

  assign is_dig = is_digit(char_code_i);
  assign is_alp = is_alpha(char_code_i);
  assign extend = !end_marker_i &&
                  (((run_kind_i == RUN_NUM) && is_dig) ||
                   ((run_kind_i == RUN_WORD) && (is_dig || is_alp)));

  // Token that closes the open run
  always_comb begin
    flush_tok        = '0;
    flush_tok.start  = run_start_ext[TOKEN_START_W-1:0];
    flush_tok.length = run_len_ext[TOKEN_LENGTH_W-1:0];
    flush_tok.line   = line_i;
    case (run_kind_i)
      RUN_NUM: flush_tok.kind = TK_NUMBER;
      RUN_WORD: begin
        if ((run_length_i == LenThree) && (word_prefix_i == WORD_DIV)) begin
          flush_tok.kind = TK_DIV;
        end else if ((run_length_i == LenThree) && (word_prefix_i == WORD_MOD)) begin
          flush_tok.kind = TK_MOD;
        end else begin
          flush_tok.kind = TK_IDENT;
        end
      end
      default: flush_tok.kind = TK_IDENT;
    endcase
  end

  // Next state and the token raised by the character itself
  always_comb begin
    run_kind_o    = run_kind_i;
    run_start_o   = run_start_i;
    run_length_o  = run_length_i;
    word_prefix_o = word_prefix_i;
    char_pos_o    = char_pos_i + POSITION_BITS'(1);
    line_o        = line_i;
    flush_valid   = 1'b0;
    second_valid  = 1'b0;
    second_tok        = '0;
    second_tok.start  = char_pos_ext[TOKEN_START_W-1:0];
    second_tok.length = TOKEN_LENGTH_W'(1);
    second_tok.line   = line_i;
    second_tok.kind   = TK_ERROR;

    if (end_marker_i) begin
      flush_valid       = (run_kind_i != RUN_NONE);
      second_valid      = 1'b1;
      second_tok.kind   = TK_EOF;
      second_tok.length = '0;
      run_kind_o        = RUN_NONE;
      run_length_o      = '0;
      word_prefix_o     = '0;
      char_pos_o        = '0;
    end else if (extend) begin
      if ((run_kind_i == RUN_WORD) && (run_length_i < LenThree)) begin
        word_prefix_o = {word_prefix_i[PREFIX_W-9:0], char_code_i};
      end
      if (run_length_i != LenMax) begin
        run_length_o = run_length_i + LENGTH_BITS'(1);
      end
    end else begin
      flush_valid   = (run_kind_i != RUN_NONE);
      run_kind_o    = RUN_NONE;
      run_length_o  = '0;
      word_prefix_o = '0;
      case (char_code_i)
        CH_SPACE, CH_CR, CH_TAB: ;
        CH_NL: begin
          if (line_i != LINE_MAX) line_o = line_i + TOKEN_LINE_W'(1);
        end
        CH_LPAREN: begin second_valid = 1'b1; second_tok.kind = TK_LPAREN; end
        CH_RPAREN: begin second_valid = 1'b1; second_tok.kind = TK_RPAREN; end
        CH_PLUS:   begin second_valid = 1'b1; second_tok.kind = TK_PLUS;   end
        CH_MINUS:  begin second_valid = 1'b1; second_tok.kind = TK_MINUS;  end
        CH_STAR:   begin second_valid = 1'b1; second_tok.kind = TK_STAR;   end
        CH_SLASH:  begin second_valid = 1'b1; second_tok.kind = TK_SLASH;  end
        CH_SEMI:   begin second_valid = 1'b1; second_tok.kind = TK_SEMI;   end
        default: begin
          if (is_dig || is_alp) begin
            // open a new run at this character
            run_kind_o    = is_dig ? RUN_NUM : RUN_WORD;
            run_start_o   = char_pos_i;
            run_length_o  = LENGTH_BITS'(1);
            word_prefix_o = {{(PREFIX_W-8){1'b0}}, char_code_i};
          end else begin
            second_valid = 1'b1;
          end
        end
      endcase
    end
  end

  // Pack into slot order; last flag marks the final token of the step
  always_comb begin
    push_o.tok0      = flush_valid ? flush_tok : second_tok;
    push_o.tok0.last = !(flush_valid && second_valid);
    push_o.tok1      = second_tok;
    push_o.tok1.last = 1'b1;
    push_o.count     = {1'b0, flush_valid} + {1'b0, second_valid};
  end

endmodule

>>> rtl/elex_tok_fifo.sv
// Small token queue: takes up to two tokens per cycle, hands out one.
module elex_tok_fifo import elex_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_en_i,
  input  elex_push_t          push_i,
  output logic                room_o,
  elex_token_if.source        tok_o
);

  elex_token_t                tok_mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]      count_q, count_d;
  logic [1:0]                 push_n;
  logic                       pop;
  elex_token_t                head;

  assign push_n = push_en_i ? push_i.count : 2'd0;
  assign pop    = tok_o.valid && tok_o.ready;

  // Room for a full two-token step
  assign room_o = (count_q < FIFO_CNT_W'(FIFO_DEPTH - 1));

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_n);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop);
    count_d  = count_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Token storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      tok_mem_q[wr_ptr_q] <= push_i.tok0;
    end
    if (push_n == 2'd2) begin
      tok_mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push_i.tok1;
    end
  end

  // Head of queue drives the output channel
  assign head               = tok_mem_q[rd_ptr_q];
  assign tok_o.valid        = (count_q != '0);
  assign tok_o.token_kind   = head.kind;
  assign tok_o.token_start  = head.start;
  assign tok_o.token_length = head.length;
  assign tok_o.token_line   = head.line;
  assign tok_o.last_of_run  = head.last;

endmodule

>>> rtl/expression_token_lexer.sv
// Each token is written into the token queue on its character transfer and is offered once it heads the queue.
// Throughput: one character per cycle while the queue has room; a step that yields two tokens needs two
//   output transfers, and the four-entry token queue sets how far input runs ahead.
// Input is taken while the queue has room for two tokens.
// Reset (async, active low) clears the run, position 0, line 1 and the queue.
`include "expression_token_lexer_defines.svh"

module expression_token_lexer import elex_pkg::*; #(
  parameter int unsigned POSITION_BITS = ELEX_POSITION_BITS,
  parameter int unsigned LENGTH_BITS   = ELEX_LENGTH_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  elex_char_if.sink     char_i,
  elex_token_if.source  tok_o
);

  elex_run_e                run_kind_q, run_kind_d;
  logic [POSITION_BITS-1:0] run_start_q, run_start_d;
  logic [LENGTH_BITS-1:0]   run_length_q, run_length_d;
  logic [PREFIX_W-1:0]      word_prefix_q, word_prefix_d;
  logic [POSITION_BITS-1:0] char_pos_q, char_pos_d;
  logic [TOKEN_LINE_W-1:0]  line_q, line_d;
  elex_push_t               push;
  logic                     room;
  logic                     accept;

  assign char_i.ready = room;
  assign accept       = char_i.valid && char_i.ready;

  // Scan step
  elex_classify #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_classify (
    .char_code_i   (char_i.char_code),
    .end_marker_i  (char_i.end_marker),
    .run_kind_i    (run_kind_q),
    .run_start_i   (run_start_q),
    .run_length_i  (run_length_q),
    .word_prefix_i (word_prefix_q),
    .char_pos_i    (char_pos_q),
    .line_i        (line_q),
    .run_kind_o    (run_kind_d),
    .run_start_o   (run_start_d),
    .run_length_o  (run_length_d),
    .word_prefix_o (word_prefix_d),
    .char_pos_o    (char_pos_d),
    .line_o        (line_d),
    .push_o        (push)
  );

  // Scanner state, updated on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_kind_q    <= RUN_NONE;
      run_start_q   <= '0;
      run_length_q  <= '0;
      word_prefix_q <= '0;
      char_pos_q    <= '0;
      line_q        <= TOKEN_LINE_W'(1);
    end else if (accept) begin
      run_kind_q    <= run_kind_d;
      run_start_q   <= run_start_d;
      run_length_q  <= run_length_d;
      word_prefix_q <= word_prefix_d;
      char_pos_q    <= char_pos_d;
      line_q        <= line_d;
    end
  end

  // Result queue
  elex_tok_fifo u_tok_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (accept),
    .push_i    (push),
    .room_o    (room),
    .tok_o     (tok_o)
  );

  // Checks
  `ELEX_ASSERT_NEXT(a_end_resets_pos, clk_i, rst_ni, accept && char_i.end_marker, char_pos_q == '0 && run_kind_q == RUN_NONE, "end marker did not clear position or run")
  `ELEX_ASSERT_NEXT(a_idle_holds_state, clk_i, rst_ni, !accept, $stable(char_pos_q) && $stable(line_q) && $stable(run_kind_q), "scanner state moved without a transfer")
  `ELEX_ASSERT_NOW(a_line_nonzero, clk_i, rst_ni, 1'b1, line_q != '0, "line count reached zero")
  `ELEX_ASSERT_NEXT(a_pair_complete, clk_i, rst_ni, tok_o.valid && !tok_o.last_of_run, tok_o.valid, "first token of a pair left without its partner")

endmodule

>>> test/elex_token_checker.sv
// Token checker: watches both lexer channels, predicts tokens and compares them.
`timescale 1ns / 100ps

module elex_token_checker import elex_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  elex_char_if        char_i,
  elex_token_if       tok_i,
  output int unsigned fail_count_o,
  output int unsigned tokens_due_o
);

  localparam logic [7:0]  LEN_TOP      = '1;

  // Predicted scanner state
  elex_run_e   scan_run;
  logic [15:0] run_origin;
  logic [7:0]  run_len;
  logic [23:0] word_head;
  logic [15:0] cursor;
  logic [15:0] line_no;

  elex_token_t due_tokens[$];
  int unsigned mismatches;

  assign fail_count_o = mismatches;

  function automatic void queue_token(input elex_kind_e kind, input logic [15:0] start,
                                      input logic [7:0] len);
    elex_token_t tok;
    tok.kind   = kind;
    tok.start  = start;
    tok.length = len;
    tok.line   = line_no;
    tok.last   = 1'b0;
    due_tokens.insert(due_tokens.size(), tok);
  endfunction

  // Emit the token of an open number or word run and close it
  function automatic void close_run();
    elex_kind_e kind;
    if (scan_run != RUN_NONE) begin
      kind = TK_NUMBER;
      if (scan_run == RUN_WORD) begin
        kind = TK_IDENT;
        if (run_len == 8'd3 && word_head == WORD_DIV) kind = TK_DIV;
        else if (run_len == 8'd3 && word_head == WORD_MOD) kind = TK_MOD;
      end
      queue_token(kind, run_origin, run_len);
      scan_run  = RUN_NONE;
      run_len   = '0;
      word_head = '0;
    end
  endfunction

  // Tokens caused by one character transfer
  function automatic void predict_step(input logic [7:0] c, input logic fin);
    int unsigned first;
    logic        num_ch;
    logic        let_ch;
    logic        emit;
    elex_kind_e  kind;
    first  = due_tokens.size();
    num_ch = c inside {[8'h30:8'h39]};
    let_ch = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    emit   = 1'b1;
    kind   = TK_ERROR;
    if (fin) begin
      close_run();
      queue_token(TK_EOF, cursor, '0);
      cursor = '0;
    end else begin
      if (scan_run == RUN_NUM && num_ch) begin
        if (run_len != LEN_TOP) run_len++;
      end else if (scan_run == RUN_WORD && (num_ch || let_ch)) begin
        if (run_len < 8'd3) word_head = {word_head[15:0], c};
        if (run_len != LEN_TOP) run_len++;
      end else begin
        close_run();
        case (c)
          CH_SPACE, CH_CR, CH_TAB: emit = 1'b0;
          CH_NL: begin
            emit = 1'b0;
            if (line_no != LINE_MAX) line_no++;
          end
          CH_LPAREN: kind = TK_LPAREN;
          CH_RPAREN: kind = TK_RPAREN;
          CH_PLUS:   kind = TK_PLUS;
          CH_MINUS:  kind = TK_MINUS;
          CH_STAR:   kind = TK_STAR;
          CH_SLASH:  kind = TK_SLASH;
          CH_SEMI:   kind = TK_SEMI;
          default: begin
            if (num_ch || let_ch) begin
              // first character of a new run
              emit       = 1'b0;
              scan_run   = num_ch ? RUN_NUM : RUN_WORD;
              run_origin = cursor;
              run_len    = 8'd1;
              word_head  = {16'h0, c};
            end
          end
        endcase
        if (emit) queue_token(kind, cursor, 8'd1);
      end
      cursor++;
    end
    if (due_tokens.size() > first) due_tokens[due_tokens.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", field, want, got);
    end
  endfunction

  // Compare output transfers, then predict from input transfers
  always @(posedge clk_i) begin : watch
    elex_token_t want;
    if (!rst_ni) begin
      scan_run   = RUN_NONE;
      run_origin = '0;
      run_len    = '0;
      word_head  = '0;
      cursor     = '0;
      line_no    = 16'd1;
      due_tokens.delete();
      mismatches = 0;
    end else begin
      if (tok_i.valid && tok_i.ready) begin
        if (due_tokens.size() == 0) begin
          mismatches++;
          $error("token transfer with none expected: token_kind %0d, token_start %0d",
                 tok_i.token_kind, tok_i.token_start);
        end else begin
          want = due_tokens.pop_front();
          check_field("token_kind", want.kind, tok_i.token_kind);
          check_field("token_start", want.start, tok_i.token_start);
          check_field("token_length", want.length, tok_i.token_length);
          check_field("token_line", want.line, tok_i.token_line);
          check_field("last_of_run", want.last, tok_i.last_of_run);
        end
      end
      if (char_i.valid && char_i.ready) predict_step(char_i.char_code, char_i.end_marker);
    end
    tokens_due_o <= due_tokens.size();
  end

endmodule

>>> test/tb_expression_token_lexer.sv
// Testbench top: clock, reset, character stimulus, token receiver and verdict.
`timescale 1ns / 100ps

module tb_expression_token_lexer;
  import elex_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned ITEM_BUDGET  = 800;
  localparam int unsigned LONG_STALL   = 200;
  localparam int unsigned TAIL_CYCLES  = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned fail_count;
  int unsigned tokens_due;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;
  bit          offering      = 1'b0;
  bit          back_to_back  = 1'b0;
  bit          long_stall_req = 1'b0;
  bit          force_ready   = 1'b0;

  string word_pool [9] = '{"div", "mod", "Div", "mOd", "dim", "mox", "divs", "mo", "d1v"};

  elex_char_if  char_if ();
  elex_token_if tok_if ();

  expression_token_lexer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .tok_o  (tok_if)
  );

  elex_token_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_i       (char_if),
    .tok_i        (tok_if),
    .fail_count_o (fail_count),
    .tokens_due_o (tokens_due)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mostly short sender gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [7:0] op_char(input int unsigned idx);
    case (idx)
      0:       return CH_LPAREN;
      1:       return CH_RPAREN;
      2:       return CH_PLUS;
      3:       return CH_MINUS;
      4:       return CH_STAR;
      5:       return CH_SLASH;
      default: return CH_SEMI;
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) != 0) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'h41 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 3) == 0) return 8'h30 + 8'($urandom_range(0, 9));
    return rand_letter();
  endfunction

  // Any byte the lexer does not know
  function automatic logic [7:0] rand_stray();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b inside {CH_TAB, CH_NL, CH_CR, CH_SPACE, CH_LPAREN, CH_RPAREN, CH_STAR,
                     CH_PLUS, CH_MINUS, CH_SLASH, CH_SEMI,
                     [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    return b;
  endfunction

  // One character transfer, then an optional gap
  task automatic send_item(input logic [7:0] c, input logic fin);
    int unsigned gap;
    char_if.char_code  <= c;
    char_if.end_marker <= fin;
    char_if.valid      <= 1'b1;
    offering = 1'b1;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    items_sent++;
    gap = back_to_back ? 0 : pick_gap();
    if (gap != 0) begin
      char_if.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Stop offering and wait until every predicted token has been taken
  task automatic wait_tokens_out();
    if (offering) begin
      char_if.valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk_i);
    while (tokens_due != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed lexemes with random content, some noise
  task automatic send_random_lexeme();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      repeat ($urandom_range(1, 5)) send_item(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
    end else if (r < 30) begin
      send_text(word_pool[$urandom_range(0, 8)]);
    end else if (r < 40) begin
      send_item(rand_letter(), 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) send_item(rand_alnum(), 1'b0);
    end else if (r < 62) begin
      send_item(op_char($urandom_range(0, 6)), 1'b0);
    end else if (r < 74) begin
      case ($urandom_range(0, 2))
        0:       send_item(CH_SPACE, 1'b0);
        1:       send_item(CH_TAB, 1'b0);
        default: send_item(CH_CR, 1'b0);
      endcase
    end else if (r < 80) begin
      send_item(CH_NL, 1'b0);
    end else if (r < 84) begin
      send_item(rand_stray(), 1'b0);
    end else if (r < 87) begin
      send_eof();
    end else begin
      repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Token receiver: random stalls, one long hold on request, always ready at the end
  initial begin : receiver
    int unsigned style;
    int unsigned span;
    tok_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      style = $urandom_range(0, 9);
      span  = $urandom_range(1, 40);
      repeat (span) begin
        @(posedge clk_i);
        if (long_stall_req) begin
          tok_if.ready <= 1'b0;
          repeat (LONG_STALL) @(posedge clk_i);
          long_stall_req = 1'b0;
        end else if (force_ready) begin
          tok_if.ready <= 1'b1;
        end else begin
          case (style)
            0, 1, 2: tok_if.ready <= 1'b1;
            3, 4, 5: tok_if.ready <= ($urandom_range(0, 3) != 0);
            6, 7:    tok_if.ready <= ($urandom_range(0, 1) != 0);
            default: tok_if.ready <= 1'b0;
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned burst_left;
    int unsigned next_pause;
    int unsigned hold_at;
    char_if.valid      <= 1'b0;
    char_if.char_code  <= '0;
    char_if.end_marker <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every token kind, blanks, newline, unknown bytes at both extremes,
    // end marker with and without an open run
    send_text("(a1+42)-*/;div mod\t\r\n");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h37, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'h00, 1'b1);

    // Long runs saturate the length; a saturated word is no keyword
    repeat (260) send_item(8'h39, 1'b0);
    send_item(CH_SEMI, 1'b0);
    send_text("div");
    repeat (256) send_item(8'h76, 1'b0);
    send_text(" divx di mod7 ");
    send_eof();
    wait_tokens_out();

    // Random part with bursts, drain pauses and one long receiver hold
    burst_left = 0;
    next_pause = items_sent + 80;
    hold_at    = items_sent + 100;
    while (items_sent < ITEM_BUDGET) begin
      if (burst_left != 0) begin
        back_to_back = 1'b1;
        burst_left--;
      end else begin
        back_to_back = 1'b0;
        if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(10, 40);
      end
      if (items_sent >= hold_at) begin
        hold_at = '1;
        long_stall_req = 1'b1;
        back_to_back   = 1'b1;
        repeat (24) send_item(op_char($urandom_range(0, 6)), 1'b0);
        back_to_back   = 1'b0;
      end
      if (items_sent >= next_pause) begin
        wait_tokens_out();
        next_pause = items_sent + 80;
      end
      send_random_lexeme();
    end
    back_to_back = 1'b0;
    send_eof();

    wait_tokens_out();
    force_ready = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
